@@ sv/vcu_pkg.sv @@
// Shared types, codes and widths for the vending controller unit.
// No dependencies; every other file in this folder imports this package.
`default_nettype none

package vcu_pkg;

    // Field widths of the event and result transactions.
    localparam int OP_W      = 3;
    localparam int SLOT_W    = 2;
    localparam int MONEY_W   = 16;
    localparam int STOCK_W   = 8;
    localparam int STATUS_W  = 4;
    localparam int NUM_SLOTS = 4;

    // Default number of slots fitted.
    localparam int SLOT_COUNT_DEFAULT = 4;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_3   = 3'd4;

    // Event operation codes.
    localparam logic [OP_W-1:0] OP_SELECT   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
    localparam logic [OP_W-1:0] OP_DISPENSE = 3'd2;
    localparam logic [OP_W-1:0] OP_REFUND   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTOCK  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_SELECTED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 4'd1;
    localparam logic [STATUS_W-1:0] ST_INSERT_FIRST = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_REFUND    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SELECT_FIRST = 4'd4;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_STOCK = 4'd5;
    localparam logic [STATUS_W-1:0] ST_INSUFFICIENT = 4'd6;
    localparam logic [STATUS_W-1:0] ST_MONEY_ADDED  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_DISPENSED    = 4'd8;
    localparam logic [STATUS_W-1:0] ST_REFUNDED     = 4'd9;
    localparam logic [STATUS_W-1:0] ST_RESTOCKED    = 4'd10;

    localparam logic [MONEY_W-1:0] BALANCE_MAX = '1;

    // Configuration seen by the event logic.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]              slot_mask;
        logic [NUM_SLOTS-1:0][MONEY_W-1:0] price;
    } cfg_t;

    // One decoded event.
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  slot_number;
        logic [MONEY_W-1:0] money_amount;
        logic [STOCK_W-1:0] restock_count;
    } event_t;

    // One result.
    typedef struct packed {
        logic [MONEY_W-1:0]  balance_now;
        logic [MONEY_W-1:0]  returned_money;
        logic [SLOT_W-1:0]   dispensed_slot;
        logic                dispensed;
        logic [STATUS_W-1:0] status_code;
    } result_t;

endpackage

`default_nettype wire

@@ sv/vcu_cfg_regs.sv @@
// Configuration registers: slot presence mask and the four slot prices.
// Depends on vcu_pkg.
`default_nettype none

module vcu_cfg_regs
    import vcu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic [NUM_SLOTS-1:0]              mask_reg;
    logic [NUM_SLOTS-1:0][MONEY_W-1:0] price_reg;

    // Writes are always taken; indexes past the last register are dropped.
    assign cfg_ready = 1'b1;

    // Register file update on each write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            price_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SLOT_MASK: mask_reg     <= cfg_data[NUM_SLOTS-1:0];
                REG_PRICE_0:   price_reg[0] <= cfg_data[MONEY_W-1:0];
                REG_PRICE_1:   price_reg[1] <= cfg_data[MONEY_W-1:0];
                REG_PRICE_2:   price_reg[2] <= cfg_data[MONEY_W-1:0];
                REG_PRICE_3:   price_reg[3] <= cfg_data[MONEY_W-1:0];
                default:       mask_reg     <= mask_reg;
            endcase
        end
    end

    assign cfg.slot_mask = mask_reg;
    assign cfg.price     = price_reg;

endmodule

`default_nettype wire

@@ sv/vcu_core.sv @@
// Event logic and machine state: mode, balance, selection and stock counts.
// Depends on vcu_pkg. State is committed when step is high.
`default_nettype none

module vcu_core
    import vcu_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   step,
    input  wire event_t evt,
    input  wire cfg_t   cfg,
    output result_t     res,
    output logic        res_known
);

    logic               mode_reg,   mode_next;
    logic [MONEY_W-1:0] bal_reg,    bal_next;
    logic [SLOT_W-1:0]  chosen_reg, chosen_next;
    logic               choice_reg, choice_next;

    logic [NUM_SLOTS-1:0][STOCK_W-1:0] stock;
    logic                              stock_we;
    logic [SLOT_W-1:0]                 stock_wr_slot;
    logic [STOCK_W-1:0]                stock_wr_val;

    logic [MONEY_W:0]   bal_sum;
    logic [MONEY_W-1:0] sel_price;
    logic [STOCK_W-1:0] sel_stock;
    logic               evt_slot_ok;
    logic               chosen_ok;

    // A slot is usable when it is fitted and enabled in the mask.
    function automatic logic slot_ok(input logic [SLOT_W-1:0] s,
                                     input logic [NUM_SLOTS-1:0] mask);
        logic fitted;
        fitted  = (32'(s) < SLOT_COUNT);
        slot_ok = fitted && mask[s];
    endfunction

    assign evt_slot_ok = slot_ok(evt.slot_number, cfg.slot_mask);
    assign chosen_ok   = slot_ok(chosen_reg, cfg.slot_mask);
    assign sel_price   = cfg.price[chosen_reg];
    assign sel_stock   = stock[chosen_reg];
    assign bal_sum     = {1'b0, bal_reg} + {1'b0, evt.money_amount};

    // One event: decide the result and the next state.
    always_comb
    begin
        mode_next          = mode_reg;
        bal_next           = bal_reg;
        chosen_next        = chosen_reg;
        choice_next        = choice_reg;
        stock_we           = 1'b0;
        stock_wr_slot      = evt.slot_number;
        stock_wr_val       = evt.restock_count;
        res_known          = 1'b1;
        res.status_code    = ST_SELECTED;
        res.dispensed      = 1'b0;
        res.dispensed_slot = '0;
        res.returned_money = '0;

        case (evt.operation)
            OP_SELECT:
            begin
                if (!evt_slot_ok)
                begin
                    res.status_code = ST_INVALID;
                end
                else
                begin
                    chosen_next     = evt.slot_number;
                    choice_next     = 1'b1;
                    res.status_code = ST_SELECTED;
                end
            end
            OP_INSERT:
            begin
                bal_next        = bal_sum[MONEY_W] ? BALANCE_MAX : bal_sum[MONEY_W-1:0];
                mode_next       = 1'b1;
                res.status_code = ST_MONEY_ADDED;
            end
            OP_DISPENSE:
            begin
                if (!mode_reg)
                begin
                    res.status_code = ST_INSERT_FIRST;
                end
                else if (!choice_reg)
                begin
                    res.status_code = ST_SELECT_FIRST;
                end
                else if (!chosen_ok)
                begin
                    res.status_code = ST_INVALID;
                end
                else if (sel_stock == '0)
                begin
                    res.status_code = ST_OUT_OF_STOCK;
                end
                else if (bal_reg < sel_price)
                begin
                    res.status_code = ST_INSUFFICIENT;
                end
                else
                begin
                    stock_we           = 1'b1;
                    stock_wr_slot      = chosen_reg;
                    stock_wr_val       = sel_stock - STOCK_W'(1);
                    res.returned_money = bal_reg - sel_price;
                    res.dispensed      = 1'b1;
                    res.dispensed_slot = chosen_reg;
                    bal_next           = '0;
                    choice_next        = 1'b0;
                    mode_next          = 1'b0;
                    res.status_code    = ST_DISPENSED;
                end
            end
            OP_REFUND:
            begin
                if (!mode_reg)
                begin
                    res.status_code = ST_NO_REFUND;
                end
                else
                begin
                    res.returned_money = bal_reg;
                    bal_next           = '0;
                    mode_next          = 1'b0;
                    res.status_code    = ST_REFUNDED;
                end
            end
            OP_RESTOCK:
            begin
                if (!evt_slot_ok)
                begin
                    res.status_code = ST_INVALID;
                end
                else
                begin
                    stock_we        = 1'b1;
                    res.status_code = ST_RESTOCKED;
                end
            end
            default:
            begin
                res_known = 1'b0;
            end
        endcase

        res.balance_now = bal_next;
    end

    // Mode, balance and selection registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            bal_reg    <= '0;
            chosen_reg <= '0;
            choice_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            bal_reg    <= bal_next;
            chosen_reg <= chosen_next;
            choice_reg <= choice_next;
        end
    end

    // Stock counters, one for each fitted slot; unfitted slots read as empty.
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_stock
        if (g < SLOT_COUNT)
        begin : g_fitted
            logic [STOCK_W-1:0] count_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    count_reg <= '0;
                end
                else if (step && stock_we && (stock_wr_slot == SLOT_W'(g)))
                begin
                    count_reg <= stock_wr_val;
                end
            end

            assign stock[g] = count_reg;
        end
        else
        begin : g_absent
            assign stock[g] = '0;
        end
    end

endmodule

`default_nettype wire

@@ sv/vending_controller_unit.sv @@
// Top level of the vending controller unit: event input register, output register.
// Depends on vcu_pkg, vcu_cfg_regs and vcu_core.
//
//  Channel   Signals                                  Direction  Content
//  s_axis    s_tvalid, s_tready, s_tdata[31:0]        in         one event per transaction
//  m_axis    m_tvalid, m_tready, m_tdata[39:0]        out        one result per known event
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in        register writes
//
// An event is taken into the input register, evaluated against the machine state
// while it is held there and the output register is free or draining, and its result
// lands in the output register, so two register stages lie between input and result.
// One event is accepted every cycle, limited only by the output register draining.
// Events with an unknown operation update nothing and give no result. Reset clears
// all state, prices and the mask.
// A stalled output holds its result while the input register can still take one event if empty.
`default_nettype none

module vending_controller_unit
    import vcu_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Fields from bit 0: operation[2:0], slot_number[4:3], money_amount[20:5],
    // restock_count[28:21], zero padding[31:29].
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: status_code[3:0], dispensed[4], dispensed_slot[6:5],
    // returned_money[22:7], balance_now[38:23], zero padding[39].
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    event_t  evt_reg;
    logic    evt_valid_reg;
    result_t res;
    logic    res_known;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step;

    vcu_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vcu_core #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .evt       (evt_reg),
        .cfg       (cfg),
        .res       (res),
        .res_known (res_known)
    );

    // The held event moves on whenever the output register is free or draining.
    assign step     = evt_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !evt_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            evt_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            evt_reg.operation     <= s_tdata[2:0];
            evt_reg.slot_number   <= s_tdata[4:3];
            evt_reg.money_amount  <= s_tdata[20:5];
            evt_reg.restock_count <= s_tdata[28:21];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= res_known;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_known)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

`default_nettype wire

@@ tb/sv/tb_vending_controller_unit.sv @@
// Self-checking testbench for vending_controller_unit: a stimulus table, then random purchases.
// Results are checked against a behavioural predictor held in this file.
// Depends on vcu_pkg and the vending_controller_unit RTL.
`timescale 1ns / 100ps

module tb_vending_controller_unit;
    import vcu_pkg::*;

    localparam int SLOTS  = SLOT_COUNT_DEFAULT;
    localparam int SETTLE = 4;        // cycles for an ignored event to leave the pipeline
    localparam int LIMIT  = 200000;   // cycle budget for the whole run
    localparam int PER_PHASE = 250;   // answered events per random setting

    // Operation codes the block ignores.
    localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

    // Table row markers.
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam logic [1:0] LOAD_NONE  = 2'd0;
    localparam logic [1:0] LOAD_FULL  = 2'd1;
    localparam logic [1:0] LOAD_DROP3 = 2'd2;

    typedef struct packed {
        logic [1:0] load;     // register setting applied before the event
        event_t     ev;
        logic       typed;    // use the result below instead of the predictor's
        result_t    want;     // balance, returned, slot, dispensed, status
    } script_row_t;

    localparam int SCRIPT_LEN = 24;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // Straight after reset: no slot exists and every price is zero.
        '{LOAD_NONE, '{OP_SELECT, 0, 0, 0}, TYPED, '{0, 0, 0, 0, ST_INVALID}},
        '{LOAD_NONE, '{OP_RESTOCK, 3, 0, 255}, TYPED, '{0, 0, 0, 0, ST_INVALID}},
        '{LOAD_NONE, '{OP_DISPENSE, 0, 0, 0}, TYPED, '{0, 0, 0, 0, ST_INSERT_FIRST}},
        '{LOAD_NONE, '{OP_REFUND, 0, 0, 0}, TYPED, '{0, 0, 0, 0, ST_NO_REFUND}},
        '{LOAD_NONE, '{OP_UNKNOWN_LO, 0, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_UNKNOWN_HI, 3, 16'hFFFF, 8'hFF}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_INSERT, 0, 0, 0}, TYPED, '{0, 0, 0, 0, ST_MONEY_ADDED}},
        '{LOAD_NONE, '{OP_DISPENSE, 0, 0, 0}, TYPED, '{0, 0, 0, 0, ST_SELECT_FIRST}},
        '{LOAD_NONE, '{OP_INSERT, 0, 16'hFFFF, 0}, TYPED,
          '{16'hFFFF, 0, 0, 0, ST_MONEY_ADDED}},
        '{LOAD_NONE, '{OP_INSERT, 0, 1, 0}, TYPED, '{16'hFFFF, 0, 0, 0, ST_MONEY_ADDED}},
        '{LOAD_NONE, '{OP_REFUND, 0, 0, 0}, TYPED, '{0, 16'hFFFF, 0, 0, ST_REFUNDED}},
        // All slots fitted; slot 1 at the top price, slot 2 never stocked.
        '{LOAD_FULL, '{OP_RESTOCK, 1, 0, 255}, TYPED, '{0, 0, 0, 0, ST_RESTOCKED}},
        '{LOAD_NONE, '{OP_SELECT, 2, 0, 0}, TYPED, '{0, 0, 0, 0, ST_SELECTED}},
        '{LOAD_NONE, '{OP_INSERT, 0, 500, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_DISPENSE, 0, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_SELECT, 1, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_DISPENSE, 0, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_INSERT, 0, 16'hFFFF, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_DISPENSE, 0, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_SELECT, 3, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_INSERT, 0, 10, 0}, PREDICTED, '0},
        // Slot 3 is withdrawn while it is selected and money is held.
        '{LOAD_DROP3, '{OP_DISPENSE, 0, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_REFUND, 0, 0, 0}, PREDICTED, '0},
        '{LOAD_NONE, '{OP_RESTOCK, 3, 0, 9}, TYPED, '{0, 0, 0, 0, ST_INVALID}}
    };

    // Ports of the block; its inputs are driven to known values from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state, mirroring the machine after reset.
    cfg_t               live_cfg   = '0;
    bit                 money_held = 1'b0;
    logic [MONEY_W-1:0] balance    = '0;
    logic [SLOT_W-1:0]  pick_slot  = '0;
    bit                 pick_valid = 1'b0;
    logic [STOCK_W-1:0] stock [NUM_SLOTS] = '{default: '0};

    result_t owed [$];          // results still to come, oldest first
    bit      calm     = 1'b0;   // no idling on either side while set
    int      errors   = 0;
    int      answered = 0;
    int      checked  = 0;
    int      vends    = 0;
    int      settings = 0;
    int      cycles   = 0;

    vending_controller_unit #(.SLOT_COUNT(SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit slot_live(input logic [SLOT_W-1:0] s);
        return (int'(s) < SLOTS) && live_cfg.slot_mask[s];
    endfunction

    function automatic event_t make_event(input logic [OP_W-1:0] op,
                                          input logic [SLOT_W-1:0] s,
                                          input logic [MONEY_W-1:0] amount,
                                          input logic [STOCK_W-1:0] count);
        event_t ev;
        ev.operation     = op;
        ev.slot_number   = s;
        ev.money_amount  = amount;
        ev.restock_count = count;
        return ev;
    endfunction

    function automatic cfg_t make_cfg(input logic [NUM_SLOTS-1:0] mask,
                                      input logic [MONEY_W-1:0] p0, input logic [MONEY_W-1:0] p1,
                                      input logic [MONEY_W-1:0] p2, input logic [MONEY_W-1:0] p3);
        cfg_t c;
        c.slot_mask = mask;
        c.price[0]  = p0;
        c.price[1]  = p1;
        c.price[2]  = p2;
        c.price[3]  = p3;
        return c;
    endfunction

    // Works out the answer to one event and advances the predicted machine.
    task automatic vend_step(input event_t ev, output bit has, output result_t r);
        logic [MONEY_W:0]   sum;
        logic [MONEY_W-1:0] price;
        r   = '0;
        has = 1'b1;
        price = live_cfg.price[pick_slot];
        case (ev.operation)
            OP_SELECT:
                if (!slot_live(ev.slot_number))
                    r.status_code = ST_INVALID;
                else
                begin
                    pick_slot     = ev.slot_number;
                    pick_valid    = 1'b1;
                    r.status_code = ST_SELECTED;
                end
            OP_INSERT:
            begin
                // The balance sticks at its maximum instead of wrapping.
                sum        = {1'b0, balance} + ev.money_amount;
                balance    = sum[MONEY_W] ? BALANCE_MAX : sum[MONEY_W-1:0];
                money_held = 1'b1;
                r.status_code = ST_MONEY_ADDED;
            end
            OP_DISPENSE:
                if (!money_held)
                    r.status_code = ST_INSERT_FIRST;
                else if (!pick_valid)
                    r.status_code = ST_SELECT_FIRST;
                else if (!slot_live(pick_slot))
                    r.status_code = ST_INVALID;
                else if (stock[pick_slot] == '0)
                    r.status_code = ST_OUT_OF_STOCK;
                else if (balance < price)
                    r.status_code = ST_INSUFFICIENT;
                else
                begin
                    stock[pick_slot]  = stock[pick_slot] - 1'b1;
                    r.returned_money  = balance - price;
                    r.dispensed       = 1'b1;
                    r.dispensed_slot  = pick_slot;
                    r.status_code     = ST_DISPENSED;
                    balance    = '0;
                    pick_valid = 1'b0;
                    money_held = 1'b0;
                end
            OP_REFUND:
                if (!money_held)
                    r.status_code = ST_NO_REFUND;
                else
                begin
                    // The selection survives a refund.
                    r.returned_money = balance;
                    r.status_code    = ST_REFUNDED;
                    balance    = '0;
                    money_held = 1'b0;
                end
            OP_RESTOCK:
                if (!slot_live(ev.slot_number))
                    r.status_code = ST_INVALID;
                else
                begin
                    stock[ev.slot_number] = ev.restock_count;
                    r.status_code = ST_RESTOCKED;
                end
            default:
                has = 1'b0;
        endcase
        r.balance_now = balance;
    endtask

    // Offers one event and, once the transaction completes, records what should come back.
    task automatic send_event(input event_t ev, input bit typed, input result_t typed_result);
        result_t r;
        bit      has;
        while (!calm && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ev.restock_count, ev.money_amount, ev.slot_number, ev.operation};
        do
            @(posedge clk);
        while (!s_tready);
        vend_step(ev, has, r);
        if (has)
        begin
            owed.push_back(typed ? typed_result : r);
            answered++;
            if (r.dispensed)
                vends++;
        end
    endtask

    // Writes every register once the block has gone quiet.
    task automatic load_settings(input cfg_t c);
        logic [CFG_IDX_W-1:0] idx;
        s_tvalid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        for (int r = REG_SLOT_MASK; r <= REG_PRICE_3; r++)
        begin
            idx = CFG_IDX_W'(r);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (idx == REG_SLOT_MASK) ? CFG_DATA_W'(c.slot_mask)
                                                 : c.price[idx - REG_PRICE_0];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        live_cfg = c;
        settings++;
    endtask

    // Mostly small sums so purchases complete, with the extremes mixed in.
    function automatic logic [MONEY_W-1:0] pick_amount();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return BALANCE_MAX;
        if (roll < 35)
            return MONEY_W'($urandom);
        return MONEY_W'($urandom_range(0, 150));
    endfunction

    function automatic logic [MONEY_W-1:0] pick_price(input int phase);
        case (phase)
            1: return MONEY_W'($urandom);
            2: return '0;
            3: return BALANCE_MAX;
            5:
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return BALANCE_MAX;
                    default: return MONEY_W'($urandom_range(0, 300));
                endcase
            default: return MONEY_W'($urandom_range(0, 300));
        endcase
    endfunction

    // One shopping visit, or a stray event with any content.
    task automatic shop_once();
        logic [SLOT_W-1:0]  s;
        logic [OP_W-1:0]    op;
        logic [STOCK_W-1:0] count;
        s = SLOT_W'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 70)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                count = ($urandom_range(0, 9) == 0) ? STOCK_W'($urandom)
                                                     : STOCK_W'($urandom_range(0, 20));
                send_event(make_event(OP_RESTOCK, s, MONEY_W'($urandom), count),
                           PREDICTED, '0);
            end
            send_event(make_event(OP_SELECT, s, MONEY_W'($urandom), STOCK_W'($urandom)),
                       PREDICTED, '0);
            repeat ($urandom_range(1, 3))
                send_event(make_event(OP_INSERT, SLOT_W'($urandom), pick_amount(),
                                      STOCK_W'($urandom)), PREDICTED, '0);
            op = ($urandom_range(0, 99) < 85) ? OP_DISPENSE : OP_REFUND;
            send_event(make_event(op, SLOT_W'($urandom), MONEY_W'($urandom),
                                  STOCK_W'($urandom)), PREDICTED, '0);
        end
        else
        begin
            op = ($urandom_range(0, 9) == 0) ? OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI))
                                              : OP_W'($urandom_range(OP_SELECT, OP_RESTOCK));
            send_event(make_event(op, s, pick_amount(), STOCK_W'($urandom)), PREDICTED, '0);
        end
    endtask

    // Result side: random back-pressure and a field-by-field check of each transaction.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        m_tready <= calm || ($urandom_range(0, 99) >= 17);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (owed.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = owed.pop_front();
                checked++;
                if (got.status_code !== want.status_code)
                begin
                    $error("status_code: expected %0d, got %0d",
                           want.status_code, got.status_code);
                    errors++;
                end
                if (got.dispensed !== want.dispensed)
                begin
                    $error("dispensed: expected %0d, got %0d", want.dispensed, got.dispensed);
                    errors++;
                end
                if (got.dispensed_slot !== want.dispensed_slot)
                begin
                    $error("dispensed_slot: expected %0d, got %0d",
                           want.dispensed_slot, got.dispensed_slot);
                    errors++;
                end
                if (got.returned_money !== want.returned_money)
                begin
                    $error("returned_money: expected %0d, got %0d",
                           want.returned_money, got.returned_money);
                    errors++;
                end
                if (got.balance_now !== want.balance_now)
                begin
                    $error("balance_now: expected %0d, got %0d",
                           want.balance_now, got.balance_now);
                    errors++;
                end
            end
        end
    end

    // Stops a hung run.
    initial
    begin : watchdog
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_vending_controller_unit: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t c;
        int   target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].load == LOAD_FULL)
                load_settings(make_cfg(4'hF, 16'd0, 16'hFFFF, 16'd100, 16'd7));
            else if (SCRIPT[i].load == LOAD_DROP3)
                load_settings(make_cfg(4'b0111, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF));
            send_event(SCRIPT[i].ev, SCRIPT[i].typed, SCRIPT[i].want);
        end

        // Random visits under several register settings; the third runs without idling.
        for (int p = 0; p < 6; p++)
        begin
            if (p == 3)
                c.slot_mask = 4'h0;
            else if (p == 1 || p == 4)
                c.slot_mask = NUM_SLOTS'($urandom_range(1, 15));
            else
                c.slot_mask = 4'hF;
            for (int s = 0; s < NUM_SLOTS; s++)
                c.price[s] = pick_price(p);
            load_settings(c);
            calm = (p == 2);
            target = answered + PER_PHASE;
            while (answered < target)
                shop_once();
        end
        calm = 1'b0;

        // Drain, then allow for anything still in flight.
        s_tvalid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE * 2) @(posedge clk);

        $display("Checked %0d results from %0d answered events under %0d register settings.",
                 checked, answered, settings);
        $display("Items vended: %0d; mismatches: %0d.", vends, errors);
        if (errors == 0)
            $display("tb_vending_controller_unit: done, clean");
        else
            $display("tb_vending_controller_unit: done, errors");
        $finish;
    end

endmodule
